// ===== design/isc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types and constants for the integer stack calculator.
// ----------------------------------------------------------------------------
package isc_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int PORT_WIDTH  = 32;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int DEPTH_W     = 7;
	localparam int CNT_W       = $clog2(VALUE_WIDTH);

	typedef logic [VALUE_WIDTH-1:0] value_t;

	// Command codes.
	localparam logic [3:0] CMD_PUSH = 4'd0;
	localparam logic [3:0] CMD_POP  = 4'd1;
	localparam logic [3:0] CMD_ADD  = 4'd2;
	localparam logic [3:0] CMD_SUB  = 4'd3;
	localparam logic [3:0] CMD_MUL  = 4'd4;
	localparam logic [3:0] CMD_DIV  = 4'd5;
	localparam logic [3:0] CMD_SQRT = 4'd6;
	localparam logic [3:0] CMD_SIN  = 4'd7;
	localparam logic [3:0] CMD_COS  = 4'd8;

	// Status codes.
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_UNDER   = 3'd1;
	localparam logic [2:0] ST_OVER    = 3'd2;
	localparam logic [2:0] ST_DIVZ    = 3'd3;
	localparam logic [2:0] ST_NEGROOT = 3'd4;

	// Sequencer states.
	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_RDA   = 9'b000000010,
		S_RDB   = 9'b000000100,
		S_NEGA  = 9'b000001000,
		S_NEGB  = 9'b000010000,
		S_ITER  = 9'b000100000,
		S_FIX   = 9'b001000000,
		S_WRITE = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;

endpackage

// ===== design/integer_stack_calculator_unit.sv =====
`timescale 1ns / 1ps
// Multiply, divide and square root iterate on one shared adder, one bit a cycle.
// Throughput: one request at a time; the next is taken once the result is in the output
// register, which holds it until taken while the next request starts.
// Reset: arst_n clears the entry count, sequencer and output valid; stack words come from pushes.
// ----------------------------------------------------------------------------
// integer_stack_calculator_unit
// Bounded stack of signed integers with push, pop and iterative arithmetic.
// ----------------------------------------------------------------------------
module integer_stack_calculator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  command,
	input  logic signed [31:0] push_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] result_value,
	output logic [6:0]  depth_after,
	output logic [2:0]  status
);

	localparam int VW = isc_pkg::VALUE_WIDTH;

	isc_pkg::state_t state_q;
	logic [isc_pkg::DEPTH_W-1:0] count_q;
	logic [3:0] cmd_q;
	isc_pkg::value_t a_q, b_q, acc_q, rem_q, res_q, rd_data_q;
	logic [2:0] stat_q;
	logic sign_q;
	logic [isc_pkg::CNT_W-1:0] cnt_q;

	isc_pkg::value_t mem [isc_pkg::STACK_DEPTH];

	logic accept, is_binary, out_free, last_full, last_half;
	logic mem_we, mem_re;
	logic [isc_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
	isc_pkg::value_t mem_wdata;
	isc_pkg::value_t add_x, add_y, add_res, mul_next;
	logic add_sub, add_carry;
	logic [VW:0] add_sum;

	// Sign extension of a stack value to the port width.
	function automatic logic signed [isc_pkg::PORT_WIDTH-1:0] PORT_W_EXT(isc_pkg::value_t v);
		return isc_pkg::PORT_WIDTH'($signed(v));
	endfunction

	assign in_ready  = (state_q == isc_pkg::S_IDLE);
	assign accept    = in_valid && in_ready;
	assign is_binary = (cmd_q == isc_pkg::CMD_ADD) || (cmd_q == isc_pkg::CMD_SUB) ||
			   (cmd_q == isc_pkg::CMD_MUL) || (cmd_q == isc_pkg::CMD_DIV);
	assign out_free  = !out_valid || out_ready;
	assign last_full = (cnt_q == isc_pkg::CNT_W'(VW - 1));
	assign last_half = (cnt_q == isc_pkg::CNT_W'(VW / 2 - 1));

	// Shared adder and subtractor.
	always_comb begin
		add_x   = acc_q;
		add_y   = b_q;
		add_sub = 1'b0;
		case (state_q)
			isc_pkg::S_NEGA: begin
				add_x = '0; add_y = a_q; add_sub = 1'b1;
			end
			isc_pkg::S_NEGB, isc_pkg::S_FIX: begin
				add_x = '0; add_y = b_q; add_sub = 1'b1;
			end
			isc_pkg::S_ITER: begin
				case (cmd_q)
					isc_pkg::CMD_ADD: begin
						add_x = b_q; add_y = a_q;
					end
					isc_pkg::CMD_SUB: begin
						add_x = b_q; add_y = a_q; add_sub = 1'b1;
					end
					isc_pkg::CMD_DIV: begin
						add_x = {rem_q[VW-2:0], b_q[VW-1]}; add_y = a_q; add_sub = 1'b1;
					end
					isc_pkg::CMD_SQRT: begin
						add_x = {rem_q[VW-3:0], a_q[VW-1:VW-2]};
						add_y = {acc_q[VW-3:0], 2'b01};
						add_sub = 1'b1;
					end
					default: begin
						add_x = acc_q; add_y = b_q;
					end
				endcase
			end
			default: begin
				add_x = acc_q;
			end
		endcase
		add_sum   = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} +
			    (VW + 1)'(add_sub);
		add_res   = add_sum[VW-1:0];
		add_carry = add_sum[VW];
		mul_next  = a_q[0] ? add_res : acc_q;
	end

	// Stack memory port control.
	always_comb begin
		mem_re    = (state_q == isc_pkg::S_IDLE) || (state_q == isc_pkg::S_RDA);
		mem_raddr = (state_q == isc_pkg::S_RDA) ?
			    isc_pkg::ADDR_W'(count_q - isc_pkg::DEPTH_W'(2)) :
			    isc_pkg::ADDR_W'(count_q - isc_pkg::DEPTH_W'(1));
		mem_we    = 1'b0;
		mem_waddr = isc_pkg::ADDR_W'(count_q);
		mem_wdata = res_q;
		if (accept && (command == isc_pkg::CMD_PUSH) &&
		    (count_q < isc_pkg::DEPTH_W'(isc_pkg::STACK_DEPTH))) begin
			mem_we    = 1'b1;
			mem_wdata = push_value[VW-1:0];
		end else if (state_q == isc_pkg::S_WRITE) begin
			mem_we    = 1'b1;
			mem_waddr = is_binary ? isc_pkg::ADDR_W'(count_q - isc_pkg::DEPTH_W'(2)) :
				    isc_pkg::ADDR_W'(count_q - isc_pkg::DEPTH_W'(1));
		end
	end

	// Stack memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rd_data_q <= mem[mem_raddr];
	end

	// Output valid: set when a result is loaded, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if ((state_q == isc_pkg::S_DONE) && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Sequencer and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= isc_pkg::S_IDLE;
			count_q   <= '0;
		end else begin
			case (state_q)
				isc_pkg::S_IDLE: begin
					if (in_valid) begin
						case (command)
							isc_pkg::CMD_PUSH: begin
								if (count_q < isc_pkg::DEPTH_W'(isc_pkg::STACK_DEPTH))
									count_q <= count_q + isc_pkg::DEPTH_W'(1);
								state_q <= isc_pkg::S_DONE;
							end
							isc_pkg::CMD_POP, isc_pkg::CMD_SQRT, isc_pkg::CMD_SIN,
							isc_pkg::CMD_COS: begin
								state_q <= (count_q == '0) ? isc_pkg::S_DONE :
									   isc_pkg::S_RDA;
							end
							isc_pkg::CMD_ADD, isc_pkg::CMD_SUB, isc_pkg::CMD_MUL,
							isc_pkg::CMD_DIV: begin
								state_q <= (count_q < isc_pkg::DEPTH_W'(2)) ?
									   isc_pkg::S_DONE : isc_pkg::S_RDA;
							end
							default: state_q <= isc_pkg::S_DONE;
						endcase
					end
				end
				isc_pkg::S_RDA: begin
					case (cmd_q)
						isc_pkg::CMD_POP: begin
							count_q <= count_q - isc_pkg::DEPTH_W'(1);
							state_q <= isc_pkg::S_DONE;
						end
						isc_pkg::CMD_SQRT: begin
							state_q <= rd_data_q[VW-1] ? isc_pkg::S_DONE :
								   isc_pkg::S_ITER;
						end
						isc_pkg::CMD_SIN, isc_pkg::CMD_COS: state_q <= isc_pkg::S_WRITE;
						default: state_q <= isc_pkg::S_RDB;
					endcase
				end
				isc_pkg::S_RDB: begin
					if (cmd_q == isc_pkg::CMD_DIV)
						state_q <= (a_q == '0) ? isc_pkg::S_DONE : isc_pkg::S_NEGA;
					else
						state_q <= isc_pkg::S_ITER;
				end
				isc_pkg::S_NEGA: state_q <= isc_pkg::S_NEGB;
				isc_pkg::S_NEGB: state_q <= isc_pkg::S_ITER;
				isc_pkg::S_ITER: begin
					case (cmd_q)
						isc_pkg::CMD_MUL: if (last_full) state_q <= isc_pkg::S_WRITE;
						isc_pkg::CMD_DIV: if (last_full) state_q <= isc_pkg::S_FIX;
						isc_pkg::CMD_SQRT: if (last_half) state_q <= isc_pkg::S_WRITE;
						default: state_q <= isc_pkg::S_WRITE;
					endcase
				end
				isc_pkg::S_FIX: state_q <= isc_pkg::S_WRITE;
				isc_pkg::S_WRITE: begin
					if (is_binary) count_q <= count_q - isc_pkg::DEPTH_W'(1);
					state_q <= isc_pkg::S_DONE;
				end
				isc_pkg::S_DONE: begin
					if (out_free) state_q <= isc_pkg::S_IDLE;
				end
				default: state_q <= isc_pkg::S_IDLE;
			endcase
		end
	end

	// Operand, iteration and result datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			isc_pkg::S_IDLE: begin
				cmd_q  <= command;
				res_q  <= '0;
				stat_q <= isc_pkg::ST_OK;
				case (command)
					isc_pkg::CMD_PUSH: begin
						if (count_q < isc_pkg::DEPTH_W'(isc_pkg::STACK_DEPTH))
							res_q <= push_value[VW-1:0];
						else
							stat_q <= isc_pkg::ST_OVER;
					end
					isc_pkg::CMD_POP, isc_pkg::CMD_SQRT, isc_pkg::CMD_SIN,
					isc_pkg::CMD_COS: begin
						if (count_q == '0) stat_q <= isc_pkg::ST_UNDER;
					end
					isc_pkg::CMD_ADD, isc_pkg::CMD_SUB, isc_pkg::CMD_MUL,
					isc_pkg::CMD_DIV: begin
						if (count_q < isc_pkg::DEPTH_W'(2)) stat_q <= isc_pkg::ST_UNDER;
					end
					default: stat_q <= isc_pkg::ST_OK;
				endcase
			end
			isc_pkg::S_RDA: begin
				a_q   <= rd_data_q;
				acc_q <= '0;
				rem_q <= '0;
				cnt_q <= '0;
				case (cmd_q)
					isc_pkg::CMD_POP: res_q <= rd_data_q;
					isc_pkg::CMD_SQRT: if (rd_data_q[VW-1]) stat_q <= isc_pkg::ST_NEGROOT;
					isc_pkg::CMD_COS: res_q <= (rd_data_q == '0) ? VW'(1) : '0;
					default: res_q <= '0;
				endcase
			end
			isc_pkg::S_RDB: begin
				b_q    <= rd_data_q;
				acc_q  <= '0;
				rem_q  <= '0;
				cnt_q  <= '0;
				sign_q <= a_q[VW-1] ^ rd_data_q[VW-1];
				if ((cmd_q == isc_pkg::CMD_DIV) && (a_q == '0)) stat_q <= isc_pkg::ST_DIVZ;
			end
			isc_pkg::S_NEGA: if (a_q[VW-1]) a_q <= add_res;
			isc_pkg::S_NEGB: if (b_q[VW-1]) b_q <= add_res;
			isc_pkg::S_ITER: begin
				cnt_q <= cnt_q + isc_pkg::CNT_W'(1);
				case (cmd_q)
					isc_pkg::CMD_MUL: begin
						acc_q <= mul_next;
						b_q   <= {b_q[VW-2:0], 1'b0};
						a_q   <= {1'b0, a_q[VW-1:1]};
						res_q <= mul_next;
					end
					isc_pkg::CMD_DIV: begin
						rem_q <= add_carry ? add_res : add_x;
						b_q   <= {b_q[VW-2:0], add_carry};
					end
					isc_pkg::CMD_SQRT: begin
						rem_q <= add_carry ? add_res : add_x;
						acc_q <= {acc_q[VW-2:0], add_carry};
						a_q   <= {a_q[VW-3:0], 2'b00};
						res_q <= {acc_q[VW-2:0], add_carry};
					end
					default: res_q <= add_res;
				endcase
			end
			isc_pkg::S_FIX: res_q <= sign_q ? add_res : b_q;
			isc_pkg::S_DONE: begin
				if (out_free) begin
					result_value <= PORT_W_EXT(res_q);
					depth_after  <= count_q;
					status       <= stat_q;
				end
			end
			default: res_q <= res_q;
		endcase
	end

`ifndef SYNTHESIS
	// The entry count never exceeds the stack depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= isc_pkg::DEPTH_W'(isc_pkg::STACK_DEPTH))
		else $error("entry count above stack depth");

	// An error result always carries a zero value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != isc_pkg::ST_OK)) |-> (result_value == '0))
		else $error("error result with nonzero value");

	// A push request with room raises the count by one.
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (command == isc_pkg::CMD_PUSH) &&
		 (count_q < isc_pkg::DEPTH_W'(isc_pkg::STACK_DEPTH)))
		|=> (count_q == $past(count_q) + isc_pkg::DEPTH_W'(1)))
		else $error("push did not advance the count");

	// A result is loaded only from the done state.
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == isc_pkg::S_DONE))
		else $error("result raised outside the done state");
`endif

endmodule
